@@ design/apm_pkg.sv @@
// apm_pkg: shared types, constants and the quarter-wave cosine table of the auto-pan modulator
`timescale 1ns / 1ps

package apm_pkg;

  localparam int TABLE_SIZE  = 1024;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int QTAB_N      = TABLE_SIZE / 4;
  localparam int QIDX_W      = IDX_W - 2;
  localparam int SAMPLE_W    = 24;
  localparam int PHASE_W     = 32;
  localparam int STEP_W      = 24;
  localparam int DEPTH_W     = 7;
  localparam int GAIN_W      = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam int FRAC_W      = 16;
  localparam int COSQ_W      = FRAC_W + 1;
  localparam int COS_W       = FRAC_W + 2;
  localparam int FACT_W      = FRAC_W + 1;
  localparam int DEN_W       = 8;
  localparam int NQ_W        = DEN_W + FRAC_W;
  localparam int SCALE_DEN   = 200;
  localparam int SCALE_ROUND = SCALE_DEN / 2;
  localparam int ROUND_Q16   = 1 << (FRAC_W - 1);

  // ceil(2^32 / 200): floor(n * RECIP_200 / 2^32) == floor(n / 200) for any 24-bit n
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_200 =
    RECIP_W'((64'd1 << RECIP_SHIFT) / SCALE_DEN + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = CFG_IDX_W'(2);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(100);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(65536);

  localparam int TAYLOR_TERMS = 10;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       block_first;
  } apm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } apm_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [IDX_W-1:0]           idx;
    logic [GAIN_W-1:0]          gain;
  } apm_item_t;

  typedef logic [QTAB_N-1:0][COSQ_W-1:0] cosq_tab_t;

  // cos of quarter-wave entry j in Q16, Q30 Taylor series, rounded half up
  function automatic logic [COSQ_W-1:0] cos_q16(input logic [QIDX_W-1:0] j);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          k;
    u    = 64'(j) << (32 - IDX_W);
    x    = (u * PI_Q30) >> 31;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return COSQ_W'((64'(sum) + 64'd8192) >> 14);
  endfunction

  function automatic cosq_tab_t build_cosq_tab();
    cosq_tab_t t;
    int        j;
    for (j = 0; j < QTAB_N; j++) begin
      t[j] = cos_q16(QIDX_W'(j));
    end
    return t;
  endfunction

  localparam cosq_tab_t COSQ_TAB = build_cosq_tab();

endpackage

@@ design/apm_front.sv @@
// apm_front: config registers, phase accumulator and gain smoothing; classifies each transfer
`timescale 1ns / 1ps

module apm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  apm_pkg::apm_in_t                    in_data,
  input  logic                                cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output apm_pkg::apm_item_t                  q_item,
  output logic [apm_pkg::DEPTH_W-1:0]         depth
);
  import apm_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [GAIN_W-1:0]  sg_r, sg_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [GAIN_W-1:0]  tgain_r;
  logic [GAIN_W:0]    gain_sum;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign gain_sum = {1'b0, sg_r} + {1'b0, tgain_r};

  always_comb begin
    sg_nxt    = sg_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (in_data.block_first) begin
        sg_nxt = gain_sum[GAIN_W:1];
      end
      phase_nxt = phase_r + PHASE_W'(step_r);
    end
  end

  assign q_push       = accept;
  assign q_item.left  = in_data.left_in;
  assign q_item.right = in_data.right_in;
  assign q_item.idx   = phase_r[PHASE_W-1 -: IDX_W];
  assign q_item.gain  = sg_nxt;
  assign depth        = depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sg_r    <= '0;
      step_r  <= '0;
      depth_r <= '0;
      tgain_r <= GAIN_RESET;
    end else begin
      phase_r <= phase_nxt;
      sg_r    <= sg_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_STEP:  step_r  <= cfg_data[STEP_W-1:0];
          CFG_DEPTH: begin
            depth_r <= (cfg_data[DEPTH_W-1:0] > DEPTH_MAX) ? DEPTH_MAX
                                                           : cfg_data[DEPTH_W-1:0];
          end
          CFG_TARGET_GAIN: tgain_r <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/apm_fifo.sv @@
// apm_fifo: short queue of classified items between front and back end
`timescale 1ns / 1ps

module apm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  apm_pkg::apm_item_t push_item,
  output logic               full,
  output logic               valid,
  output apm_pkg::apm_item_t head,
  input  logic               pop
);
  import apm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  apm_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
    end
    if (pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/apm_back.sv @@
// apm_back: shared scale pipeline, left then right channel, pairing and output register
`timescale 1ns / 1ps

module apm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [apm_pkg::DEPTH_W-1:0] depth,
  input  logic                        q_valid,
  input  apm_pkg::apm_item_t          q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output apm_pkg::apm_out_t           out_data
);
  import apm_pkg::*;

  localparam int FJ_W    = QIDX_W + 1;
  localparam int NSUM_W  = DEPTH_W + COS_W + 1;
  localparam int RP_W    = NQ_W + RECIP_W;
  localparam int GP_W    = GAIN_W + FACT_W;
  localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int Y_W     = PROD_W - FRAC_W;
  localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic adv;
  logic ch_r, ch_nxt;

  // issue and table lookup
  logic signed [SAMPLE_W-1:0] is_x;
  logic [IDX_W-1:0]           is_idx;
  logic [IDX_W-1:0]           fold_a;
  logic [FJ_W-1:0]            fold_j;
  logic                       fold_neg;
  logic [COSQ_W-1:0]          cos_mag;
  logic signed [COS_W-1:0]    is_cos;

  logic                       s1_v_r, s1_ch_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;
  logic [GAIN_W-1:0]          s1_gain_r;
  logic signed [COS_W-1:0]    s1_cos_r;

  logic [NQ_W-1:0]            base;
  logic signed [NSUM_W-1:0]   dc;
  logic signed [NSUM_W-1:0]   nsum;

  logic                       s2_v_r, s2_ch_r;
  logic signed [SAMPLE_W-1:0] s2_x_r;
  logic [GAIN_W-1:0]          s2_gain_r;
  logic [NQ_W-1:0]            s2_nq_r;

  logic [RP_W-1:0]            recip_prod;

  logic                       s3_v_r, s3_ch_r;
  logic signed [SAMPLE_W-1:0] s3_x_r;
  logic [GAIN_W-1:0]          s3_gain_r;
  logic [FACT_W-1:0]          s3_f_r;

  logic [GP_W-1:0]            gprod;

  logic                       s4_v_r, s4_ch_r;
  logic signed [SAMPLE_W-1:0] s4_x_r;
  logic [GAIN_W-1:0]          s4_gq_r;

  logic signed [PROD_W-1:0]   prod;

  logic                       s5_v_r, s5_ch_r;
  logic signed [PROD_W-1:0]   s5_prod_r;

  logic signed [PROD_W-1:0]   rnd;
  logic [Y_W-1:0]             y;
  logic                       y_fits;
  logic [SAMPLE_W-1:0]        sat_y;

  logic [SAMPLE_W-1:0]        lhold_r;
  logic                       out_valid_r, out_valid_nxt;
  apm_out_t                   out_data_r;

  assign adv = !out_valid_r || !out_stall;

  // left lane on the first pass over a queue entry, right lane on the second
  always_comb begin
    ch_nxt = ch_r;
    if (adv && q_valid) begin
      ch_nxt = !ch_r;
    end
  end
  assign q_pop = adv && q_valid && ch_r;

  assign is_x   = ch_r ? q_head.right : q_head.left;
  assign is_idx = ch_r ? q_head.idx + IDX_W'(TABLE_SIZE / 2) : q_head.idx;

  // fold full-turn index onto the first quadrant
  always_comb begin
    fold_a   = is_idx[IDX_W-1] ? (IDX_W'(0) - is_idx) : is_idx;
    fold_neg = 1'b0;
    fold_j   = FJ_W'(fold_a);
    if (fold_a > IDX_W'(QTAB_N)) begin
      fold_j   = FJ_W'(IDX_W'(TABLE_SIZE / 2) - fold_a);
      fold_neg = 1'b1;
    end
  end

  // quarter turn exactly reads zero
  assign cos_mag = fold_j[QIDX_W] ? '0 : COSQ_TAB[fold_j[QIDX_W-1:0]];
  assign is_cos  = fold_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  // N + 100 = 65536*(200-d) + d*c + 100
  assign base = {DEN_W'(SCALE_DEN) - DEN_W'(depth), {FRAC_W{1'b0}}};
  assign dc   = $signed({1'b0, depth}) * s1_cos_r;
  assign nsum = $signed({2'b0, base}) + dc + $signed(NSUM_W'(SCALE_ROUND));

  assign recip_prod = s2_nq_r * RECIP_200;

  assign gprod = s3_gain_r * s3_f_r + GP_W'(ROUND_Q16);

  assign prod = s4_x_r * $signed({1'b0, s4_gq_r});

  assign rnd    = s5_prod_r + $signed(PROD_W'(ROUND_Q16));
  assign y      = rnd[PROD_W-1:FRAC_W];
  assign y_fits = (y[Y_W-1:SAMPLE_W-1] == '0) || (y[Y_W-1:SAMPLE_W-1] == '1);
  assign sat_y  = y_fits ? y[SAMPLE_W-1:0] : (y[Y_W-1] ? SAT_MIN : SAT_MAX);

  assign out_valid_nxt = adv ? (s5_v_r && s5_ch_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s1_v_r <= q_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
        s5_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_r   <= ch_r;
      s1_x_r    <= is_x;
      s1_gain_r <= q_head.gain;
      s1_cos_r  <= is_cos;

      s2_ch_r   <= s1_ch_r;
      s2_x_r    <= s1_x_r;
      s2_gain_r <= s1_gain_r;
      s2_nq_r   <= nsum[NQ_W-1:0];

      s3_ch_r   <= s2_ch_r;
      s3_x_r    <= s2_x_r;
      s3_gain_r <= s2_gain_r;
      s3_f_r    <= recip_prod[RECIP_SHIFT +: FACT_W];

      s4_ch_r   <= s3_ch_r;
      s4_x_r    <= s3_x_r;
      s4_gq_r   <= gprod[FRAC_W +: GAIN_W];

      s5_ch_r   <= s4_ch_r;
      s5_prod_r <= prod;

      if (s5_v_r && !s5_ch_r) begin
        lhold_r <= sat_y;
      end
      if (s5_v_r && s5_ch_r) begin
        out_data_r.left_out  <= lhold_r;
        out_data_r.right_out <= sat_y;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/stereo_auto_pan_modulator_core.sv @@
// stereo_auto_pan_modulator_core: stereo auto-panner top level.
// Each input transfer carries one stereo sample pair and yields one output pair. A cosine
// LFO driven by a 32-bit phase accumulator (step set through cfg) scales left and right
// with opposite-phase gains at the configured depth, times a smoothed gain that moves
// halfway to the target gain on every sample flagged as a block start. Until the first
// block start the gain is zero and every output is zero. The back end runs left and right
// through one shared scaling pipeline, one channel per cycle unless the output stalls,
// and overlaps successive queue entries. A pair passes the queue, the scale pipeline and
// the output register. A two-entry queue sits between the front end (config, phase, gain
// smoothing) and the back end, so input transfers continue while the output is stalled
// until the queue fills. Config writes are meant for idle periods only.
`timescale 1ns / 1ps

module stereo_auto_pan_modulator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  apm_pkg::apm_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output apm_pkg::apm_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import apm_pkg::*;

  logic               q_push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  apm_item_t          q_item;
  apm_item_t          q_head;
  logic [DEPTH_W-1:0] depth;

  apm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .depth     (depth)
  );

  apm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  apm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .depth     (depth),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/apm_checker.sv @@
// apm_checker: port-level assertions for the auto-pan modulator, bound to the top level
`timescale 1ns / 1ps

module apm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input apm_pkg::apm_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input apm_pkg::apm_out_t out_data
);

  localparam int PEND_W = 4;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              seen_first_r, seen_first_nxt;
  logic              in_xfer;
  logic              out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + PEND_W'(1);
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - PEND_W'(1);
    end
    seen_first_nxt = seen_first_r || (in_xfer && in_data.block_first);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      seen_first_r <= 1'b0;
    end else begin
      pend_r       <= pend_nxt;
      seen_first_r <= seen_first_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  a_no_extra_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("output offered with no input outstanding");

  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_first_r |-> out_data == '0)
    else $error("nonzero output before first block start");

endmodule

bind stereo_auto_pan_modulator_core apm_checker u_apm_checker (.*);

@@ tb/stereo_auto_pan_modulator_core_test.sv @@
// Self-checking testbench for the stereo auto-pan modulator core.
`timescale 1ns / 1ps

module stereo_auto_pan_modulator_core_test;
  import apm_pkg::*;

  localparam int LUT_N = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 212;
  localparam int HOLD_LEN = 80;
  localparam int FREE_LEN = 60;
  localparam int MAX_PRINTS = 50;
  localparam logic [63:0] LFO_PI_Q30 = 64'd3373259426;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic [2:0] {
    PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH, PACE_BACKLOG
  } pace_t;

  typedef struct {
    row_kind_t                   kind;
    logic [CFG_IDX_W-1:0]        reg_idx;
    logic [CFG_DATA_W-1:0]       reg_val;
    logic signed [SAMPLE_W-1:0]  smp_l;
    logic signed [SAMPLE_W-1:0]  smp_r;
    logic                        first;
    logic                        typed;
    logic signed [SAMPLE_W-1:0]  exp_l;
    logic signed [SAMPLE_W-1:0]  exp_r;
  } plan_row_t;

  localparam int PLAN_N = 32;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  apm_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  apm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // panner model state
  int                    cos_tab [LUT_N];
  logic [31:0]           lfo_phase;
  logic [GAIN_W-1:0]     gain_smooth;
  logic [STEP_W-1:0]     reg_step;
  logic [DEPTH_W-1:0]    reg_depth;
  logic [GAIN_W-1:0]     reg_target;

  apm_out_t              pending_pairs [$];
  int                    err_count = 0;
  pace_t                 pace = PACE_FREE;
  int                    src_idle_pct = 0;
  int                    sink_stall_pct = 0;
  int                    hold_left = 0;
  int                    free_left = 0;

  plan_row_t plan [PLAN_N] = '{
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MIN, 1'b0, 1'b1, 24'sd0, 24'sd0},
    '{ROW_ITEM, '0, '0, -24'sd1, 24'sd1, 1'b0, 1'b1, 24'sd0, 24'sd0},
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MIN, 1'b1, 1'b1, 24'sd4194304, -24'sd4194304},
    '{ROW_ITEM, '0, '0, 24'sd0, 24'sd0, 1'b0, 1'b1, 24'sd0, 24'sd0},
    '{ROW_ITEM, '0, '0, 24'sd12345, -24'sd54321, 1'b1, 1'b0, '0, '0},
    '{ROW_CFG, CFG_TARGET_GAIN, 24'd655360, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MIN, 1'b1, 1'b1, SMP_MAX, SMP_MIN},
    '{ROW_ITEM, '0, '0, 24'sd1000, -24'sd1000, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_TARGET_GAIN, 24'd1048575, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MIN, SMP_MAX, 1'b1, 1'b1, SMP_MIN, SMP_MAX},
    '{ROW_CFG, CFG_TARGET_GAIN, 24'd65536, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_DEPTH, 24'd100, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_PHASE_STEP, 24'hFFFFFF, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MAX, 1'b1, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MIN, SMP_MIN, 1'b1, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd4096, -24'sd4096, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, -24'sd1, -24'sd1, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_DEPTH, 24'd127, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MIN, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd777777, -24'sd777777, 1'b1, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd1, -24'sd1, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_UNUSED, 24'hFFFFFF, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd300000, -24'sd300000, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MIN, SMP_MAX, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_PHASE_STEP, 24'h400000, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_DEPTH, 24'd50, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd5000000, -24'sd5000000, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, -24'sd5000000, 24'sd5000000, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, 24'sd2000, 24'sd2000, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG, CFG_TARGET_GAIN, 24'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, SMP_MAX, SMP_MIN, 1'b1, 1'b0, '0, '0},
    '{ROW_ITEM, '0, '0, -24'sd123456, 24'sd654321, 1'b0, 1'b0, '0, '0}
  };

  stereo_auto_pan_modulator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // cos(2*pi*i/LUT_N) in Q16 via Q30 Taylor series, folded into the first quadrant
  function automatic int lfo_cos(int i);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      r;
    logic        neg;
    u = 64'(i) << 22;
    neg = 1'b0;
    if (u >= 64'h8000_0000) u = 64'h1_0000_0000 - u;
    if (u > 64'h4000_0000) begin
      u = 64'h8000_0000 - u;
      neg = 1'b1;
    end
    x = (u * LFO_PI_Q30) >> 31;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    acc = longint'(64'd1 << 30);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (acc + 8192) >>> 14;
    return neg ? int'(-r) : int'(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pan_sample(logic signed [SAMPLE_W-1:0] x,
                                                           logic [9:0] idx);
    longint d;
    longint n;
    longint f;
    longint gq;
    longint y;
    d = (reg_depth > 7'd100) ? 100 : longint'(reg_depth);
    n = 65536 * (200 - d) + d * longint'(cos_tab[idx]);
    f = (n + 100) / 200;
    gq = (longint'(gain_smooth) * f + 32768) >>> 16;
    y = (longint'(x) * gq + 32768) >>> 16;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return SAMPLE_W'(y);
  endfunction

  function automatic apm_out_t pan_pair(apm_in_t d);
    apm_out_t    o;
    logic [31:0] ph_r;
    if (d.block_first) gain_smooth = GAIN_W'(({1'b0, gain_smooth} + {1'b0, reg_target}) >> 1);
    ph_r = lfo_phase + 32'h8000_0000;
    o.left_out = pan_sample(d.left_in, lfo_phase[31:22]);
    o.right_out = pan_sample(d.right_in, ph_r[31:22]);
    lfo_phase = lfo_phase + 32'(reg_step);
    return o;
  endfunction

  task automatic flag_mismatch(string what);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  task automatic check_pair(apm_out_t got);
    apm_out_t want;
    if (pending_pairs.size() == 0) begin
      flag_mismatch($sformatf("output transfer with nothing pending: %0d %0d",
                              got.left_out, got.right_out));
      return;
    end
    want = pending_pairs.pop_front();
    if (got.left_out !== want.left_out)
      flag_mismatch($sformatf("left_out %0d, expected %0d", got.left_out, want.left_out));
    if (got.right_out !== want.right_out)
      flag_mismatch($sformatf("right_out %0d, expected %0d", got.right_out, want.right_out));
  endtask

  // output side: checker plus stall generation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_pair(out_data);
    if (pace == PACE_BACKLOG) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left = free_left - 1;
        out_stall <= 1'b0;
      end else begin
        hold_left = HOLD_LEN - 1;
        free_left = FREE_LEN;
        out_stall <= 1'b1;
      end
    end else begin
      hold_left = 0;
      free_left = 0;
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PHASE_STEP:  reg_step = val[STEP_W-1:0];
      CFG_DEPTH:       reg_depth = val[DEPTH_W-1:0];
      CFG_TARGET_GAIN: reg_target = val[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_item(apm_in_t d, logic typed, apm_out_t typed_exp);
    apm_out_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = pan_pair(d);
    pending_pairs.push_back(typed ? typed_exp : pred);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pace(pace_t p);
    pace <= p;
    case (p)
      PACE_SRC_IDLE:   begin src_idle_pct <= 65; sink_stall_pct <= 0;  end
      PACE_SINK_STALL: begin src_idle_pct <= 0;  sink_stall_pct <= 65; end
      PACE_BOTH:       begin src_idle_pct <= 17; sink_stall_pct <= 17; end
      default:         begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    apm_in_t               d;
    apm_out_t              e;
    pace_t                 p;
    logic [CFG_DATA_W-1:0] v_step;
    logic [CFG_DATA_W-1:0] v_depth;
    logic [CFG_DATA_W-1:0] v_gain;
    int                    blk_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < LUT_N; i++) cos_tab[i] = lfo_cos(i);
    lfo_phase = '0;
    gain_smooth = '0;
    reg_step = '0;
    reg_depth = '0;
    reg_target = GAIN_W'(65536);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_N; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        d.left_in = plan[i].smp_l;
        d.right_in = plan[i].smp_r;
        d.block_first = plan[i].first;
        e.left_out = plan[i].exp_l;
        e.right_out = plan[i].exp_r;
        push_item(d, plan[i].typed, e);
      end
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: p = PACE_FREE;
        1: p = PACE_SRC_IDLE;
        2: p = PACE_SINK_STALL;
        3: p = PACE_BOTH;
        4: p = PACE_BACKLOG;
        default: p = pace_t'($urandom_range(0, 4));
      endcase
      set_pace(p);
      if (ph == 0) begin
        v_step = 24'hFFFFFF;
        v_depth = 24'd100;
        v_gain = 24'd655360;
      end else if (ph == 1) begin
        v_step = '0;
        v_depth = '0;
        v_gain = '0;
      end else begin
        case ($urandom_range(0, 3))
          0: v_step = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000001;
          1: v_step = CFG_DATA_W'($urandom_range(0, 2000000));
          default: v_step = CFG_DATA_W'($urandom());
        endcase
        case ($urandom_range(0, 5))
          0: v_depth = 24'd0;
          1: v_depth = 24'd100;
          2: v_depth = CFG_DATA_W'($urandom());
          default: v_depth = CFG_DATA_W'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 4))
          0: v_gain = 24'd655360;
          1: v_gain = CFG_DATA_W'($urandom_range(655361, 1048575));
          default: v_gain = CFG_DATA_W'($urandom_range(0, 655360));
        endcase
      end
      write_reg(CFG_PHASE_STEP, v_step);
      write_reg(CFG_DEPTH, v_depth);
      write_reg(CFG_TARGET_GAIN, v_gain);
      blk_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        d.block_first = (blk_left == 0);
        if (blk_left == 0) blk_left = $urandom_range(1, 48);
        blk_left--;
        if ($urandom_range(0, 9) == 0) d.block_first = 1'($urandom_range(0, 1));
        d.left_in = rand_sample();
        d.right_in = rand_sample();
        push_item(d, 1'b0, '0);
      end
      settle();
    end

    set_pace(PACE_FREE);
    if (err_count == 0 && pending_pairs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
